// ----- rtl/core/priority_flag_goal_scheduler_assert.svh -----
// assertion macros for the priority flag goal scheduler
`ifndef PRIORITY_FLAG_GOAL_SCHEDULER_ASSERT_SVH
`define PRIORITY_FLAG_GOAL_SCHEDULER_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define PFGS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define PFGS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pfgs_pkg.sv -----
// shared constants, types and helpers for the priority flag goal scheduler
package pfgs_pkg;

    localparam int SLOTS    = 16;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PRI_W    = 8;
    localparam int RES_W    = 8;
    localparam int OP_W     = 2;
    localparam int ID_W     = 4;
    localparam int FPRI_W   = 8;
    localparam int VEC_W    = 16;
    localparam int STATUS_W = 2;

    localparam logic [SLOTS-1:0] ONE_HOT0 = SLOTS'(1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_ADD     = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_STOPALL = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_ADD_IGN  = 2'd1,
        ST_RM_EMPTY = 2'd2
    } t_status;

    // slot under test by the shared compare unit
    typedef struct packed {
        logic              valid;
        logic              running;
        logic              seen;
        logic [SLOT_W-1:0] idx;
        logic [PRI_W-1:0]  pri;
        logic [RES_W-1:0]  res;
    } t_probe;

    // candidate or next-candidate record
    typedef struct packed {
        logic              have;
        logic [SLOT_W-1:0] idx;
        logic [PRI_W-1:0]  pri;
        logic [RES_W-1:0]  res;
    } t_cand;

    typedef struct packed {
        logic blocks;
        logic preempts;
        logic take;
    } t_step;

    typedef struct packed {
        logic              run_we;
        logic [SLOTS-1:0]  run_nxt;
        logic              val_we;
        logic [SLOTS-1:0]  val_nxt;
        logic              ent_we;
        logic [SLOT_W-1:0] ent_idx;
        logic [PRI_W-1:0]  ent_pri;
        logic [RES_W-1:0]  ent_res;
    } t_tbl_ctl;

    typedef struct packed {
        logic             valid;
        logic [SLOTS-1:0] started;
        logic [SLOTS-1:0] stopped;
        t_status          status;
    } t_done;

    function automatic logic [VEC_W-1:0] to_vec(input logic [SLOTS-1:0] v);
        return VEC_W'(v);
    endfunction

    function automatic logic [SLOTS-1:0] from_vec(input logic [VEC_W-1:0] v);
        return SLOTS'(v);
    endfunction

    function automatic logic [SLOT_W-1:0] to_idx(input logic [ID_W-1:0] id);
        return SLOT_W'(id);
    endfunction

    function automatic logic id_ok(input logic [ID_W-1:0] id);
        return int'(id) < SLOTS;
    endfunction

    function automatic logic [PRI_W-1:0] to_pri(input logic [FPRI_W-1:0] p);
        return PRI_W'(p);
    endfunction

endpackage

// ----- rtl/core/pfgs_table.sv -----
// slot table: valid and running flags, priority and resource entries
module pfgs_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pfgs_pkg::t_tbl_ctl             i_ctl,
    input  logic [pfgs_pkg::SLOT_W-1:0]    i_rd_idx,
    output logic [pfgs_pkg::SLOTS-1:0]     o_valid_vec,
    output logic [pfgs_pkg::SLOTS-1:0]     o_running_vec,
    output logic [pfgs_pkg::PRI_W-1:0]     o_rd_pri,
    output logic [pfgs_pkg::RES_W-1:0]     o_rd_res
);

    logic [pfgs_pkg::SLOTS-1:0] r_valid;
    logic [pfgs_pkg::SLOTS-1:0] r_running;
    logic [pfgs_pkg::PRI_W-1:0] r_pri [pfgs_pkg::SLOTS];
    logic [pfgs_pkg::RES_W-1:0] r_res [pfgs_pkg::SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_running <= '0;
        end else begin
            if (i_ctl.val_we) begin
                r_valid <= i_ctl.val_nxt;
            end
            if (i_ctl.run_we) begin
                r_running <= i_ctl.run_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ent_we) begin
            r_pri[i_ctl.ent_idx] <= i_ctl.ent_pri;
            r_res[i_ctl.ent_idx] <= i_ctl.ent_res;
        end
    end

    assign o_valid_vec   = r_valid;
    assign o_running_vec = r_running;
    assign o_rd_pri      = r_pri[i_rd_idx];
    assign o_rd_res      = r_res[i_rd_idx];

endmodule

// ----- rtl/core/pfgs_step.sv -----
// shared compare unit: one slot against the candidate and the running minimum
module pfgs_step (
    input  pfgs_pkg::t_probe i_probe,
    input  pfgs_pkg::t_cand  i_cand,
    input  pfgs_pkg::t_cand  i_nxt,
    output pfgs_pkg::t_step  o_step
);

    logic conflict;

    assign conflict = i_cand.have && (i_probe.idx != i_cand.idx) && i_probe.running &&
                      ((i_probe.res & i_cand.res) != '0);

    always_comb begin
        o_step.blocks   = conflict && (i_probe.pri < i_cand.pri);
        o_step.preempts = conflict && (i_probe.pri > i_cand.pri);
        o_step.take     = i_probe.valid && !i_probe.seen &&
                          (!i_nxt.have || (i_probe.pri < i_nxt.pri));
    end

endmodule

// ----- rtl/core/pfgs_seq.sv -----
// sequencer: command decode and the per-round slot scan of a tick
module pfgs_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [pfgs_pkg::OP_W-1:0]       i_opcode,
    input  logic [pfgs_pkg::ID_W-1:0]       i_slot_id,
    input  logic [pfgs_pkg::FPRI_W-1:0]     i_new_priority,
    input  logic [pfgs_pkg::RES_W-1:0]      i_new_resources,
    input  logic [pfgs_pkg::VEC_W-1:0]      i_usable_bits,
    input  logic [pfgs_pkg::VEC_W-1:0]      i_continue_bits,
    input  logic [pfgs_pkg::SLOTS-1:0]      i_valid_vec,
    input  logic [pfgs_pkg::SLOTS-1:0]      i_running_vec,
    input  logic [pfgs_pkg::PRI_W-1:0]      i_rd_pri,
    input  logic [pfgs_pkg::RES_W-1:0]      i_rd_res,
    output logic [pfgs_pkg::SLOT_W-1:0]     o_rd_idx,
    output pfgs_pkg::t_tbl_ctl              o_tbl,
    output pfgs_pkg::t_done                 o_done,
    input  logic                            i_done_ack
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DONE
    } t_state;

    t_state                        r_state,   n_state;
    logic [pfgs_pkg::SLOT_W-1:0]   r_j,       n_j;
    pfgs_pkg::t_cand               r_cand,    n_cand;
    pfgs_pkg::t_cand               r_nxt,     n_nxt;
    logic                          r_blk,     n_blk;
    logic [pfgs_pkg::SLOTS-1:0]    r_pre,     n_pre;
    logic [pfgs_pkg::SLOTS-1:0]    r_seen,    n_seen;
    logic [pfgs_pkg::SLOTS-1:0]    r_usable,  n_usable;
    logic [pfgs_pkg::SLOTS-1:0]    r_started, n_started;
    logic [pfgs_pkg::SLOTS-1:0]    r_stopped, n_stopped;
    pfgs_pkg::t_status             r_status,  n_status;

    pfgs_pkg::t_probe              probe;
    pfgs_pkg::t_step               step;
    logic [pfgs_pkg::SLOT_W-1:0]   id;
    logic [pfgs_pkg::SLOTS-1:0]    id_bit;
    logic [pfgs_pkg::SLOTS-1:0]    cont;
    logic                          eligible;

    assign probe.valid   = i_valid_vec[r_j];
    assign probe.running = i_running_vec[r_j];
    assign probe.seen    = r_seen[r_j];
    assign probe.idx     = r_j;
    assign probe.pri     = i_rd_pri;
    assign probe.res     = i_rd_res;

    pfgs_step u_step (
        .i_probe (probe),
        .i_cand  (r_cand),
        .i_nxt   (r_nxt),
        .o_step  (step)
    );

    assign o_rd_idx   = r_j;
    assign o_in_ready = (r_state == S_IDLE);
    assign id         = pfgs_pkg::to_idx(i_slot_id);
    assign id_bit     = pfgs_pkg::ONE_HOT0 << id;
    assign cont       = pfgs_pkg::from_vec(i_continue_bits);
    assign eligible   = r_cand.have && !i_running_vec[r_cand.idx] &&
                        r_usable[r_cand.idx] && !r_blk;

    always_comb begin
        n_state   = r_state;
        n_j       = r_j;
        n_cand    = r_cand;
        n_nxt     = r_nxt;
        n_blk     = r_blk;
        n_pre     = r_pre;
        n_seen    = r_seen;
        n_usable  = r_usable;
        n_started = r_started;
        n_stopped = r_stopped;
        n_status  = r_status;
        o_tbl     = '0;
        o_tbl.run_nxt = i_running_vec;
        o_tbl.val_nxt = i_valid_vec;
        o_tbl.ent_idx = id;
        o_tbl.ent_pri = pfgs_pkg::to_pri(i_new_priority);
        o_tbl.ent_res = i_new_resources;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_started = '0;
                    n_stopped = '0;
                    n_status  = pfgs_pkg::ST_OK;
                    n_state   = S_DONE;
                    case (pfgs_pkg::t_op'(i_opcode))
                        pfgs_pkg::OP_TICK: begin
                            o_tbl.run_we  = 1'b1;
                            o_tbl.run_nxt = i_running_vec & cont;
                            n_stopped     = i_running_vec & ~cont;
                            n_usable      = pfgs_pkg::from_vec(i_usable_bits);
                            n_seen        = '0;
                            n_cand        = '0;
                            n_nxt         = '0;
                            n_blk         = 1'b0;
                            n_pre         = '0;
                            n_j           = '0;
                            n_state       = S_SCAN;
                        end
                        pfgs_pkg::OP_ADD: begin
                            if (!pfgs_pkg::id_ok(i_slot_id) || i_valid_vec[id]) begin
                                n_status = pfgs_pkg::ST_ADD_IGN;
                            end else begin
                                o_tbl.val_we  = 1'b1;
                                o_tbl.val_nxt = i_valid_vec | id_bit;
                                o_tbl.run_we  = 1'b1;
                                o_tbl.run_nxt = i_running_vec & ~id_bit;
                                o_tbl.ent_we  = 1'b1;
                            end
                        end
                        pfgs_pkg::OP_REMOVE: begin
                            if (!pfgs_pkg::id_ok(i_slot_id) || !i_valid_vec[id]) begin
                                n_status = pfgs_pkg::ST_RM_EMPTY;
                            end else begin
                                n_stopped     = i_running_vec & id_bit;
                                o_tbl.val_we  = 1'b1;
                                o_tbl.val_nxt = i_valid_vec & ~id_bit;
                                o_tbl.run_we  = 1'b1;
                                o_tbl.run_nxt = i_running_vec & ~id_bit;
                            end
                        end
                        default: begin
                            n_stopped     = i_running_vec;
                            o_tbl.run_we  = 1'b1;
                            o_tbl.run_nxt = '0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (step.blocks) begin
                    n_blk = 1'b1;
                end
                if (step.preempts) begin
                    n_pre = r_pre | (pfgs_pkg::ONE_HOT0 << r_j);
                end
                if (step.take) begin
                    n_nxt = '{have: 1'b1, idx: r_j, pri: i_rd_pri, res: i_rd_res};
                end
                if (r_j == pfgs_pkg::LAST_SLOT) begin
                    n_state = S_DECIDE;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_DECIDE: begin
                if (eligible) begin
                    o_tbl.run_we  = 1'b1;
                    o_tbl.run_nxt = (i_running_vec & ~r_pre) |
                                    (pfgs_pkg::ONE_HOT0 << r_cand.idx);
                    n_stopped     = r_stopped | r_pre;
                    n_started     = r_started | (pfgs_pkg::ONE_HOT0 << r_cand.idx);
                end
                if (r_nxt.have) begin
                    n_cand  = r_nxt;
                    n_seen  = r_seen | (pfgs_pkg::ONE_HOT0 << r_nxt.idx);
                    n_nxt   = '0;
                    n_blk   = 1'b0;
                    n_pre   = '0;
                    n_j     = '0;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_done_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_j       <= '0;
            r_cand    <= '0;
            r_nxt     <= '0;
            r_blk     <= 1'b0;
            r_pre     <= '0;
            r_seen    <= '0;
            r_usable  <= '0;
            r_started <= '0;
            r_stopped <= '0;
            r_status  <= pfgs_pkg::ST_OK;
        end else begin
            r_state   <= n_state;
            r_j       <= n_j;
            r_cand    <= n_cand;
            r_nxt     <= n_nxt;
            r_blk     <= n_blk;
            r_pre     <= n_pre;
            r_seen    <= n_seen;
            r_usable  <= n_usable;
            r_started <= n_started;
            r_stopped <= n_stopped;
            r_status  <= n_status;
        end
    end

    always_comb begin
        o_done.valid   = (r_state == S_DONE);
        o_done.started = r_started;
        o_done.stopped = r_stopped;
        o_done.status  = r_status;
    end

endmodule

// ----- rtl/core/priority_flag_goal_scheduler.sv -----
// add, remove and stop-all: from acceptance to the done state, then the output register
// a tick runs one round per valid slot plus a final round, each a scan over all slots;
// the single compare unit visits one slot per cycle
// a new transaction is taken only once the last result has gone to the output register
// reset: synchronous active low; clears valid and running flags, sequencer and output valid
// top level: slot table, tick sequencer and output register
`include "priority_flag_goal_scheduler_assert.svh"

module priority_flag_goal_scheduler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [pfgs_pkg::OP_W-1:0]         i_opcode,
    input  logic [pfgs_pkg::ID_W-1:0]         i_slot_id,
    input  logic [pfgs_pkg::FPRI_W-1:0]       i_new_priority,
    input  logic [pfgs_pkg::RES_W-1:0]        i_new_resources,
    input  logic [pfgs_pkg::VEC_W-1:0]        i_usable_bits,
    input  logic [pfgs_pkg::VEC_W-1:0]        i_continue_bits,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [pfgs_pkg::VEC_W-1:0]        o_started_bits,
    output logic [pfgs_pkg::VEC_W-1:0]        o_stopped_bits,
    output logic [pfgs_pkg::VEC_W-1:0]        o_active_bits,
    output logic [pfgs_pkg::STATUS_W-1:0]     o_status
);

    pfgs_pkg::t_tbl_ctl               tbl_ctl;
    pfgs_pkg::t_done                  done;
    logic [pfgs_pkg::SLOTS-1:0]       valid_vec;
    logic [pfgs_pkg::SLOTS-1:0]       running_vec;
    logic [pfgs_pkg::SLOT_W-1:0]      rd_idx;
    logic [pfgs_pkg::PRI_W-1:0]       rd_pri;
    logic [pfgs_pkg::RES_W-1:0]       rd_res;
    logic                             done_ack;

    logic                             r_out_valid;
    logic [pfgs_pkg::VEC_W-1:0]       r_started;
    logic [pfgs_pkg::VEC_W-1:0]       r_stopped;
    logic [pfgs_pkg::VEC_W-1:0]       r_active;
    logic [pfgs_pkg::STATUS_W-1:0]    r_status;

    pfgs_table u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (tbl_ctl),
        .i_rd_idx      (rd_idx),
        .o_valid_vec   (valid_vec),
        .o_running_vec (running_vec),
        .o_rd_pri      (rd_pri),
        .o_rd_res      (rd_res)
    );

    pfgs_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_slot_id       (i_slot_id),
        .i_new_priority  (i_new_priority),
        .i_new_resources (i_new_resources),
        .i_usable_bits   (i_usable_bits),
        .i_continue_bits (i_continue_bits),
        .i_valid_vec     (valid_vec),
        .i_running_vec   (running_vec),
        .i_rd_pri        (rd_pri),
        .i_rd_res        (rd_res),
        .o_rd_idx        (rd_idx),
        .o_tbl           (tbl_ctl),
        .o_done          (done),
        .i_done_ack      (done_ack)
    );

    assign done_ack = done.valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_ack) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_ack) begin
            r_started <= pfgs_pkg::to_vec(done.started);
            r_stopped <= pfgs_pkg::to_vec(done.stopped);
            r_active  <= pfgs_pkg::to_vec(running_vec);
            r_status  <= done.status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_started_bits = r_started;
    assign o_stopped_bits = r_stopped;
    assign o_active_bits  = r_active;
    assign o_status       = r_status;

    `PFGS_ASSERT_NOW(a_run_in_valid, i_clk, i_rst_n, 1'b1, (running_vec & ~valid_vec) == '0, "running slot not valid")
    `PFGS_ASSERT_NOW(a_started_active, i_clk, i_rst_n, o_out_valid, (o_started_bits & ~o_active_bits) == '0, "started slot not active")
    `PFGS_ASSERT_NOW(a_err_no_change, i_clk, i_rst_n, o_out_valid && (o_status != pfgs_pkg::ST_OK), (o_started_bits == '0) && (o_stopped_bits == '0), "rejected transaction changed slots")
    `PFGS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready held after accept")

endmodule
